// ----- hdl/mip_pkg.sv -----
package mip_pkg;

  // Field widths fixed by the interface
  localparam int OPCODE_WIDTH    = 2;
  localparam int IN_SAMPLE_WIDTH = 32;
  localparam int PRED_WIDTH      = 41;
  localparam int NUM_POINTS      = 4;

  // Arithmetic precision
  localparam int SAMPLE_WIDTH     = 32;
  localparam int WEIGHT_FRAC_BITS = 6;

  // Partner factors are quarter units, so three of them give 1/64 units
  localparam int FAC_WIDTH       = 5;
  localparam int BASE_FRAC_BITS  = 6;
  localparam int BASE_WEIGHT_W   = 9;
  localparam int WEIGHT_SHIFT    = WEIGHT_FRAC_BITS - BASE_FRAC_BITS;
  localparam int WEIGHT_WIDTH    = BASE_WEIGHT_W + WEIGHT_SHIFT;
  localparam int PROD_WIDTH      = WEIGHT_WIDTH + SAMPLE_WIDTH;
  localparam int SUM_GROWTH      = PROD_WIDTH + 2;
  localparam int SUM_WIDTH       = (SUM_GROWTH > PRED_WIDTH) ? SUM_GROWTH : PRED_WIDTH;
  localparam int EXT_WIDTH       = (SAMPLE_WIDTH > IN_SAMPLE_WIDTH) ?
                                   SAMPLE_WIDTH : IN_SAMPLE_WIDTH;

  typedef enum logic [OPCODE_WIDTH-1:0] {
    OP_CUBIC    = 2'd0,
    OP_QUAD     = 2'd1,
    OP_EXTRAP   = 2'd2,
    OP_RESERVED = 2'd3
  } opcode_t;

  typedef logic signed [FAC_WIDTH-1:0]     factor_t;
  typedef logic signed [BASE_WEIGHT_W-1:0] base_weight_t;
  typedef logic signed [WEIGHT_WIDTH-1:0]  weight_t;
  typedef logic signed [SAMPLE_WIDTH-1:0]  sample_t;
  typedef logic signed [PROD_WIDTH-1:0]    product_t;
  typedef logic signed [SUM_WIDTH-1:0]     sum_t;

  typedef weight_t  weight_set_t  [NUM_POINTS];
  typedef sample_t  sample_set_t  [NUM_POINTS];
  typedef product_t product_set_t [NUM_POINTS];

  // Row = weighted point, column = partner
  localparam factor_t FAC_CUBIC [NUM_POINTS][NUM_POINTS] = '{
    '{ 5'sd0, -5'sd2,  5'sd1,  5'sd2},
    '{ 5'sd6,  5'sd0,  5'sd2,  5'sd3},
    '{ 5'sd3,  5'sd2,  5'sd0,  5'sd6},
    '{ 5'sd2,  5'sd1, -5'sd2,  5'sd0}
  };
  localparam factor_t FAC_QUAD [NUM_POINTS][NUM_POINTS] = '{
    '{ 5'sd0, -5'sd2,  5'sd1,  5'sd0},
    '{ 5'sd6,  5'sd0,  5'sd2,  5'sd0},
    '{ 5'sd3,  5'sd2,  5'sd0,  5'sd0},
    '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0}
  };
  localparam factor_t FAC_EXTRAP [NUM_POINTS][NUM_POINTS] = '{
    '{ 5'sd0, -5'sd6, -5'sd1,  5'sd0},
    '{ 5'sd10, 5'sd0, -5'sd2,  5'sd0},
    '{ 5'sd5,  5'sd6,  5'sd0,  5'sd0},
    '{ 5'sd0,  5'sd0,  5'sd0,  5'sd0}
  };

  localparam factor_t FAC_ONE = 5'sd4;

  function automatic factor_t partner_factor(opcode_t op, logic [1:0] k, logic [1:0] j);
    factor_t f;
    case (op)
      OP_CUBIC:  f = FAC_CUBIC[k][j];
      OP_QUAD:   f = FAC_QUAD[k][j];
      OP_EXTRAP: f = FAC_EXTRAP[k][j];
      default:   f = FAC_ONE;
    endcase
    return f;
  endfunction

  // Sign-extend a sample port value from IN_SAMPLE_WIDTH bits
  function automatic sample_t sext_sample(logic [IN_SAMPLE_WIDTH-1:0] x);
    logic signed [EXT_WIDTH-1:0] t;
    t = EXT_WIDTH'(signed'(x));
    return signed'(t[SAMPLE_WIDTH-1:0]);
  endfunction

endpackage

// ----- hdl/mip_weight_gen.sv -----
module mip_weight_gen (
  input  mip_pkg::opcode_t     op,
  input  logic [3:0]           vld,
  output mip_pkg::weight_set_t weight
);

  logic [3:0] pts;

  // Absent fourth point acts as masked: factor one, weight zero
  always_comb begin
    pts = vld;
    if (op != mip_pkg::OP_CUBIC) begin
      pts[3] = 1'b0;
    end
  end

  for (genvar k = 0; k < mip_pkg::NUM_POINTS; k++) begin : g_point
    mip_pkg::base_weight_t base;
    mip_pkg::factor_t      f [mip_pkg::NUM_POINTS];

    always_comb begin
      for (int j = 0; j < mip_pkg::NUM_POINTS; j++) begin
        if (j == k || !pts[j]) begin
          f[j] = mip_pkg::FAC_ONE;
        end else begin
          f[j] = mip_pkg::partner_factor(op, 2'(k), 2'(j));
        end
      end
    end

    always_comb begin
      base = mip_pkg::base_weight_t'(1);
      if (op == mip_pkg::OP_RESERVED || !pts[k]) begin
        base = '0;
      end else begin
        for (int j = 0; j < mip_pkg::NUM_POINTS; j++) begin
          if (j != k) begin
            base = mip_pkg::base_weight_t'(base * mip_pkg::base_weight_t'(f[j]));
          end
        end
      end
    end

    assign weight[k] = mip_pkg::weight_t'(base) <<< mip_pkg::WEIGHT_SHIFT;
  end

endmodule

// ----- hdl/masked_interpolation_predictor.sv -----
// Channel  | Handshake             | Payload
// ---------+-----------------------+-------------------------------------------
// input    | in_valid / in_ready   | opcode, sample_a..sample_d, valid_a..valid_d
// output   | out_valid / out_ready | prediction
//
// Three register stages: input, weighted products, sum. One transaction per
// cycle is sustained while the output is not stalled.
// The critical path is one 9x32 weight multiply in the product stage.
// Each stage advances when its successor is empty or advancing; an output
// stall backs up through the stages and holds in_ready low only when all are full.
// Synchronous reset clears the stage valid flags only.
module masked_interpolation_predictor (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mip_pkg::OPCODE_WIDTH-1:0]    opcode,
  input  logic signed [mip_pkg::IN_SAMPLE_WIDTH-1:0] sample_a,
  input  logic signed [mip_pkg::IN_SAMPLE_WIDTH-1:0] sample_b,
  input  logic signed [mip_pkg::IN_SAMPLE_WIDTH-1:0] sample_c,
  input  logic signed [mip_pkg::IN_SAMPLE_WIDTH-1:0] sample_d,
  input  logic                                valid_a,
  input  logic                                valid_b,
  input  logic                                valid_c,
  input  logic                                valid_d,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mip_pkg::PRED_WIDTH-1:0] prediction
);

  // Stage 1: input register
  logic                  in_stage_valid;
  mip_pkg::opcode_t      in_op;
  logic [3:0]            in_vld;
  mip_pkg::sample_set_t  in_sample;

  // Stage 2: products
  logic                  prod_valid;
  mip_pkg::product_set_t prod;

  // Stage 3: result
  mip_pkg::sum_t         sum_next;

  mip_pkg::weight_set_t  weight;
  logic                  prod_ready;
  logic                  out_stage_ready;

  assign out_stage_ready = !out_valid || out_ready;
  assign prod_ready      = !prod_valid || out_stage_ready;
  assign in_ready        = !in_stage_valid || prod_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_stage_valid <= 1'b0;
      prod_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (in_ready) begin
        in_stage_valid <= in_valid;
      end
      if (prod_ready) begin
        prod_valid <= in_stage_valid;
      end
      if (out_stage_ready) begin
        out_valid <= prod_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_op        <= mip_pkg::opcode_t'(opcode);
      in_vld       <= {valid_d, valid_c, valid_b, valid_a};
      in_sample[0] <= mip_pkg::sext_sample(sample_a);
      in_sample[1] <= mip_pkg::sext_sample(sample_b);
      in_sample[2] <= mip_pkg::sext_sample(sample_c);
      in_sample[3] <= mip_pkg::sext_sample(sample_d);
    end
  end

  mip_weight_gen u_weight_gen (
    .op     (in_op),
    .vld    (in_vld),
    .weight (weight)
  );

  always_ff @(posedge clk) begin
    if (prod_ready && in_stage_valid) begin
      for (int k = 0; k < mip_pkg::NUM_POINTS; k++) begin
        prod[k] <= mip_pkg::product_t'(weight[k]) * mip_pkg::product_t'(in_sample[k]);
      end
    end
  end

  assign sum_next = mip_pkg::sum_t'(prod[0]) + mip_pkg::sum_t'(prod[1])
                  + mip_pkg::sum_t'(prod[2]) + mip_pkg::sum_t'(prod[3]);

  // Wrap to the output field width
  always_ff @(posedge clk) begin
    if (out_stage_ready && prod_valid) begin
      prediction <= signed'(sum_next[mip_pkg::PRED_WIDTH-1:0]);
    end
  end

endmodule

// ----- test/testbench.sv -----
`timescale 1ns / 100ps

module testbench;

  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int HOLD_START   = 600;
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 12;
  localparam logic [31:0] S_MAX = 32'h7fff_ffff;
  localparam logic [31:0] S_MIN = 32'h8000_0000;

  // Partner factors in quarter units, indexed [opcode][weighted point][partner]
  localparam int FACTORS [3][4][4] = '{
    '{'{ 0, -2,  1,  2}, '{ 6,  0,  2,  3}, '{ 3,  2,  0,  6}, '{ 2,  1, -2,  0}},
    '{'{ 0, -2,  1,  0}, '{ 6,  0,  2,  0}, '{ 3,  2,  0,  0}, '{ 0,  0,  0,  0}},
    '{'{ 0, -6, -1,  0}, '{10,  0, -2,  0}, '{ 5,  6,  0,  0}, '{ 0,  0,  0,  0}}
  };

  typedef struct {
    mip_pkg::opcode_t op;
    logic [3:0][31:0] smp;   // index 0 is sample_a
    logic [3:0]       vld;   // bit 0 is valid_a
    bit               drain; // wait for all results before offering
  } neighbours_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [mip_pkg::OPCODE_WIDTH-1:0] opcode = '0;
  logic signed [mip_pkg::IN_SAMPLE_WIDTH-1:0] sample_a = '0;
  logic signed [mip_pkg::IN_SAMPLE_WIDTH-1:0] sample_b = '0;
  logic signed [mip_pkg::IN_SAMPLE_WIDTH-1:0] sample_c = '0;
  logic signed [mip_pkg::IN_SAMPLE_WIDTH-1:0] sample_d = '0;
  logic valid_a = 1'b0;
  logic valid_b = 1'b0;
  logic valid_c = 1'b0;
  logic valid_d = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [mip_pkg::PRED_WIDTH-1:0] prediction;

  neighbours_t                           pending_items [$];
  neighbours_t                           offered;
  logic signed [mip_pkg::PRED_WIDTH-1:0] expected_preds [$];
  int                                    accepted_count = 0;
  int                                    total_items = 0;
  int                                    mismatches = 0;
  int                                    send_gap = 0;
  int                                    recv_gap = 0;
  int                                    hold_left = 0;
  int                                    cycle = 0;

  masked_interpolation_predictor dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .opcode(opcode),
    .sample_a(sample_a), .sample_b(sample_b), .sample_c(sample_c), .sample_d(sample_d),
    .valid_a(valid_a), .valid_b(valid_b), .valid_c(valid_c), .valid_d(valid_d),
    .out_valid(out_valid), .out_ready(out_ready),
    .prediction(prediction)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Refit weights over the live neighbours and sum exactly in 1/64 units
  function automatic logic signed [mip_pkg::PRED_WIDTH-1:0] interpolate(neighbours_t it);
    logic [3:0] live;
    longint     acc;
    longint     s;
    longint     w;
    acc = 0;
    if (it.op == mip_pkg::OP_RESERVED) return '0;
    live = (it.op == mip_pkg::OP_CUBIC) ? it.vld : (it.vld & 4'b0111);
    for (int k = 0; k < 4; k++) begin
      if (live[k]) begin
        w = 1;
        for (int j = 0; j < 4; j++) begin
          if (j != k) w = w * (live[j] ? FACTORS[int'(it.op)][k][j] : 4);
        end
        s = longint'(signed'(it.smp[k]));
        s = (s <<< (64 - mip_pkg::SAMPLE_WIDTH)) >>> (64 - mip_pkg::SAMPLE_WIDTH);
        acc = acc + ((w * s) <<< (mip_pkg::WEIGHT_FRAC_BITS - 6));
      end
    end
    return acc[mip_pkg::PRED_WIDTH-1:0];
  endfunction

  // Mostly short gaps, now and then a long one
  function automatic int idle_length();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [31:0] random_sample();
    case ($urandom_range(0, 19))
      0: return S_MAX;
      1: return S_MIN;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  function automatic mip_pkg::opcode_t random_op();
    int r;
    r = $urandom_range(0, 9);
    if (r < 3) return mip_pkg::OP_CUBIC;
    if (r < 6) return mip_pkg::OP_QUAD;
    if (r < 9) return mip_pkg::OP_EXTRAP;
    return mip_pkg::OP_RESERVED;
  endfunction

  task automatic push_item(input mip_pkg::opcode_t op, input logic [31:0] a,
                           input logic [31:0] b, input logic [31:0] c,
                           input logic [31:0] d,
                           input logic [3:0] vld, input bit drain);
    neighbours_t it;
    it.op    = op;
    it.smp   = {d, c, b, a};
    it.vld   = vld;
    it.drain = drain;
    pending_items.push_back(it);
    total_items++;
  endtask

  // Driver: hold the payload until the transaction is taken
  always @(posedge clk) begin
    bit taken;
    taken = in_valid && in_ready;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || taken) begin
      if (taken) begin
        expected_preds.push_back(interpolate(offered));
        accepted_count++;
        send_gap = idle_length();
      end
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (pending_items.size() > 0 &&
                   !(pending_items[0].drain && expected_preds.size() > 0)) begin
        offered = pending_items.pop_front();
        in_valid <= 1'b1;
        opcode   <= offered.op;
        sample_a <= offered.smp[0];
        sample_b <= offered.smp[1];
        sample_c <= offered.smp[2];
        sample_d <= offered.smp[3];
        valid_a  <= offered.vld[0];
        valid_b  <= offered.vld[1];
        valid_c  <= offered.vld[2];
        valid_d  <= offered.vld[3];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off so the pipeline backs up into in_ready
  always @(posedge clk) begin
    if (rst) begin
      hold_left <= 0;
    end else if (cycle == HOLD_START) begin
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // Monitor: compare each transaction with the oldest expectation
  always @(posedge clk) begin
    logic signed [mip_pkg::PRED_WIDTH-1:0] want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_preds.size() == 0) begin
          $error("unexpected transaction: prediction %0d", prediction);
          mismatches++;
        end else begin
          want = expected_preds.pop_front();
          if (prediction !== want) begin
            $error("prediction mismatch: expected %0d, actual %0d", want, prediction);
            mismatches++;
          end
        end
      end
      if (hold_left > 0) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
        if ($urandom_range(0, 9) == 0) recv_gap = idle_length();
      end
    end
  end

  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    // Extremes per opcode, all neighbours live
    push_item(mip_pkg::OP_CUBIC,  S_MAX, S_MAX, S_MAX, S_MAX, 4'b1111, 0);
    push_item(mip_pkg::OP_QUAD,   S_MAX, S_MAX, S_MAX, S_MAX, 4'b1111, 0);
    push_item(mip_pkg::OP_EXTRAP, S_MAX, S_MAX, S_MAX, S_MAX, 4'b1111, 0);
    push_item(mip_pkg::OP_CUBIC,  S_MIN, S_MIN, S_MIN, S_MIN, 4'b1111, 0);
    push_item(mip_pkg::OP_QUAD,   S_MIN, S_MIN, S_MIN, S_MIN, 4'b1111, 0);
    push_item(mip_pkg::OP_EXTRAP, S_MIN, S_MIN, S_MIN, S_MIN, 4'b1111, 0);
    push_item(mip_pkg::OP_CUBIC,  S_MAX, S_MIN, S_MAX, S_MIN, 4'b1111, 0);
    push_item(mip_pkg::OP_EXTRAP, S_MIN, S_MAX, S_MIN, S_MAX, 4'b1111, 0);
    // Everything masked
    push_item(mip_pkg::OP_CUBIC,  S_MAX, S_MIN, S_MAX, S_MIN, 4'b0000, 0);
    push_item(mip_pkg::OP_QUAD,   S_MAX, S_MIN, S_MAX, S_MIN, 4'b0000, 0);
    push_item(mip_pkg::OP_EXTRAP, S_MAX, S_MIN, S_MAX, S_MIN, 4'b0000, 0);
    // Reserved opcode
    push_item(mip_pkg::OP_RESERVED, S_MAX, S_MIN, 32'd12345, S_MAX, 4'b1111, 0);
    // Fourth neighbour is ignored outside cubic
    push_item(mip_pkg::OP_QUAD,   32'd7, 32'd9, 32'd11, S_MAX, 4'b1000, 0);
    push_item(mip_pkg::OP_EXTRAP, 32'd7, 32'd9, 32'd11, S_MIN, 4'b1111, 0);
    push_item(mip_pkg::OP_QUAD,   32'd7, 32'd9, 32'd11, S_MIN, 4'b0111, 0);
    // One neighbour masked at a time
    push_item(mip_pkg::OP_CUBIC, 32'd1000, -32'sd2000, 32'd3000, -32'sd4000, 4'b1110, 0);
    push_item(mip_pkg::OP_CUBIC, 32'd1000, -32'sd2000, 32'd3000, -32'sd4000, 4'b1101, 0);
    push_item(mip_pkg::OP_CUBIC, 32'd1000, -32'sd2000, 32'd3000, -32'sd4000, 4'b1011, 0);
    push_item(mip_pkg::OP_CUBIC, 32'd1000, -32'sd2000, 32'd3000, -32'sd4000, 4'b0111, 0);
    push_item(mip_pkg::OP_QUAD,   S_MAX, S_MIN, S_MAX, 32'd0, 4'b0101, 0);
    push_item(mip_pkg::OP_EXTRAP, S_MIN, S_MAX, S_MIN, 32'd0, 4'b0110, 0);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      push_item(random_op(), random_sample(), random_sample(), random_sample(),
                random_sample(),
                ($urandom_range(0, 9) < 6) ? 4'b1111 : 4'($urandom),
                (n == 0) || (n == RANDOM_ITEMS / 2));
    end

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    while (accepted_count < total_items) @(posedge clk);
    while (expected_preds.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);

    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
